### rtl/dle_etx_deframer_checksum_top_assert.svh
// ---------------------------------------------------------------------------
// DLE/ETX deframer assertion macros
// Shared assertion forms for the deframer checker.
// ---------------------------------------------------------------------------
`ifndef DLE_ETX_DEFRAMER_CHECKSUM_TOP_ASSERT_SVH
`define DLE_ETX_DEFRAMER_CHECKSUM_TOP_ASSERT_SVH

// checked at every edge, reset included
`define DETX_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

// checked only outside reset
`define DETX_ASSERT_RUN(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`endif

### rtl/detx_pkg.sv
// ---------------------------------------------------------------------------
// DLE/ETX deframer package
// Byte codes, command and result types shared by the deframer modules.
// ---------------------------------------------------------------------------
package detx_pkg;

	localparam logic [7:0] DleByte = 8'h10;
	localparam logic [7:0] EtxByte = 8'h03;

	localparam int PosW = 9;
	localparam logic [PosW-1:0] PosMax     = 9'h1FF;
	localparam logic [PosW-1:0] PosCommand = 9'd1;
	localparam logic [PosW-1:0] PosSize    = 9'd2;
	localparam logic [PosW-1:0] PosPayload = 9'd3;

	localparam logic KindPayload = 1'b0;
	localparam logic KindEnd     = 1'b1;

	// work handed from the classifier to the frame engine
	typedef enum logic {
		OP_KEEP,
		OP_END
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} cmd_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] payload_value;
		logic [7:0] payload_index;
		logic [7:0] frame_command;
		logic [7:0] frame_size;
		logic       checksum_ok;
	} res_t;

endpackage

### rtl/detx_fifo.sv
// ---------------------------------------------------------------------------
// DLE/ETX deframer queue
// Small register queue with push/full and pop/empty sides.
// ---------------------------------------------------------------------------
module detx_fifo #(
	parameter type item_t = logic,
	parameter int  Depth  = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t wr_data,
	output logic  full,
	input  logic  pop,
	output item_t rd_data,
	output logic  empty
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	item_t            mem_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CntW'(Depth));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/detx_front.sv
// ---------------------------------------------------------------------------
// DLE/ETX deframer front end
// Unstuffs DLE pairs and classifies each byte as kept or end of frame.
// ---------------------------------------------------------------------------
module detx_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [7:0]       rx_byte,
	output logic             full,
	input  logic             cmd_full,
	output logic             cmd_push,
	output detx_pkg::cmd_t   cmd
);

	logic [7:0] previous_byte_q;
	logic       accept;
	logic       prev_dle;
	logic       drop;
	logic       is_end;

	assign full     = cmd_full;
	assign accept   = push && !cmd_full;
	assign prev_dle = (previous_byte_q == detx_pkg::DleByte);
	assign drop     = prev_dle && (rx_byte == detx_pkg::DleByte);
	assign is_end   = prev_dle && (rx_byte == detx_pkg::EtxByte);

	assign cmd_push = accept && !drop;
	assign cmd.op   = is_end ? detx_pkg::OP_END : detx_pkg::OP_KEEP;
	assign cmd.data = rx_byte;

	// a dropped stuffing DLE clears the history so a third DLE is kept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			previous_byte_q <= '0;
		end else if (accept) begin
			previous_byte_q <= drop ? 8'h00 : rx_byte;
		end
	end

endmodule

### rtl/detx_back.sv
// ---------------------------------------------------------------------------
// DLE/ETX deframer frame engine
// Tracks frame position, holds header fields and checks the byte sum.
// ---------------------------------------------------------------------------
module detx_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_empty,
	input  detx_pkg::cmd_t   cmd,
	output logic             cmd_pop,
	input  logic             res_full,
	output logic             res_push,
	output detx_pkg::res_t   res
);

	logic [detx_pkg::PosW-1:0] byte_position_q;
	logic [7:0]                held_command_q;
	logic [7:0]                held_size_q;
	logic [7:0]                running_sum_q;
	logic [7:0]                held_checksum_q;

	logic                      go;
	logic                      is_end;
	logic [detx_pkg::PosW-1:0] chk_pos;
	logic                      at_command;
	logic                      at_size;
	logic                      at_payload;
	logic                      at_checksum;
	logic [detx_pkg::PosW-1:0] pay_idx;
	logic [7:0]                total;

	assign go      = !cmd_empty && !res_full;
	assign cmd_pop = go;
	assign is_end  = (cmd.op == detx_pkg::OP_END);

	assign chk_pos     = detx_pkg::PosPayload + {1'b0, held_size_q};
	assign at_command  = (byte_position_q == detx_pkg::PosCommand);
	assign at_size     = (byte_position_q == detx_pkg::PosSize);
	assign at_payload  = (byte_position_q >= detx_pkg::PosPayload) &&
	                     (byte_position_q < chk_pos);
	assign at_checksum = (byte_position_q == chk_pos);
	assign pay_idx     = byte_position_q - detx_pkg::PosPayload;
	assign total       = running_sum_q + held_checksum_q;

	assign res_push = go && (is_end || at_payload);

	always_comb begin
		res = '0;
		if (is_end) begin
			res.kind          = detx_pkg::KindEnd;
			res.frame_command = held_command_q;
			res.frame_size    = held_size_q;
			res.checksum_ok   = (total == 8'h00);
		end else begin
			res.kind          = detx_pkg::KindPayload;
			res.payload_value = cmd.data;
			res.payload_index = pay_idx[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q <= '0;
			held_command_q  <= '0;
			held_size_q     <= '0;
			running_sum_q   <= '0;
			held_checksum_q <= '0;
		end else if (go) begin
			if (is_end) begin
				byte_position_q <= '0;
				held_command_q  <= '0;
				held_size_q     <= '0;
				running_sum_q   <= '0;
				held_checksum_q <= '0;
			end else begin
				if (at_command) begin
					held_command_q <= cmd.data;
				end
				if (at_size) begin
					held_size_q <= cmd.data;
				end
				if (at_command || at_size || at_payload) begin
					running_sum_q <= running_sum_q + cmd.data;
				end
				if (at_checksum) begin
					held_checksum_q <= cmd.data;
				end
				if (byte_position_q != detx_pkg::PosMax) begin
					byte_position_q <= byte_position_q + 1'b1;
				end
			end
		end
	end

endmodule

### rtl/dle_etx_deframer_checksum_top.sv
// ---------------------------------------------------------------------------
// DLE/ETX deframer with checksum check
// Unstuffs a DLE/ETX framed byte stream and reports payload and frame end.
// ---------------------------------------------------------------------------
// Input channel: rx_byte with push/full; a transfer happens on a clock edge
// with push high and full low. Any byte may be offered every cycle.
// Result channel: the oldest result sits on kind and the payload/frame ports
// while empty is low; a transfer happens on an edge with pop high and empty
// low. A kind 0 result is one payload byte with its index, a kind 1 result
// is a frame end with command, size and the checksum flag.
// A byte passes a front classifier (DLE pair dropping, DLE ETX detection)
// into a command queue, then the frame engine, then the result queue.
// A byte's result is registered in the command queue and then in the result
// queue. Throughput: one byte per cycle while the result queue is not full,
// set by the frame engine which handles one queued command per cycle.
// Stuffing DLEs and bytes that produce no result still take one slot in
// their path; the stuffing DLE never reaches the command queue.
// When the receiver stalls, the result queue fills, the frame engine stops,
// the command queue fills and full rises; nothing is lost.
// Reset (arst_n low) empties both queues and clears all frame state.
// ---------------------------------------------------------------------------
module dle_etx_deframer_checksum_top #(
	parameter int CmdDepth = 2,
	parameter int ResDepth = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] rx_byte,
	output logic       empty,
	input  logic       pop,
	output logic       kind,
	output logic [7:0] payload_value,
	output logic [7:0] payload_index,
	output logic [7:0] frame_command,
	output logic [7:0] frame_size,
	output logic       checksum_ok
);

	// front to command queue
	logic            cmd_push;
	logic            cmd_full;
	detx_pkg::cmd_t  cmd_wr;

	// command queue to frame engine
	logic            cmd_pop;
	logic            cmd_empty;
	detx_pkg::cmd_t  cmd_rd;

	// frame engine to result queue
	logic            res_push;
	logic            res_full;
	detx_pkg::res_t  res_wr;
	detx_pkg::res_t  res_rd;

	detx_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.rx_byte  (rx_byte),
		.full     (full),
		.cmd_full (cmd_full),
		.cmd_push (cmd_push),
		.cmd      (cmd_wr)
	);

	// decouples classification from the frame engine
	detx_fifo #(
		.item_t (detx_pkg::cmd_t),
		.Depth  (CmdDepth)
	) u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (cmd_push),
		.wr_data (cmd_wr),
		.full    (cmd_full),
		.pop     (cmd_pop),
		.rd_data (cmd_rd),
		.empty   (cmd_empty)
	);

	detx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_rd),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_wr)
	);

	// output queue: the engine keeps running while a result waits
	detx_fifo #(
		.item_t (detx_pkg::res_t),
		.Depth  (ResDepth)
	) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.wr_data (res_wr),
		.full    (res_full),
		.pop     (pop),
		.rd_data (res_rd),
		.empty   (empty)
	);

	assign kind          = res_rd.kind;
	assign payload_value = res_rd.payload_value;
	assign payload_index = res_rd.payload_index;
	assign frame_command = res_rd.frame_command;
	assign frame_size    = res_rd.frame_size;
	assign checksum_ok   = res_rd.checksum_ok;

endmodule

### rtl/detx_checker.sv
// ---------------------------------------------------------------------------
// DLE/ETX deframer port checker
// Watches the top level ports for reset, hold and result field rules.
// ---------------------------------------------------------------------------
`include "dle_etx_deframer_checksum_top_assert.svh"

module detx_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       push,
	input logic       full,
	input logic [7:0] rx_byte,
	input logic       empty,
	input logic       pop,
	input logic       kind,
	input logic [7:0] payload_value,
	input logic [7:0] payload_index,
	input logic [7:0] frame_command,
	input logic [7:0] frame_size,
	input logic       checksum_ok
);

	logic unused_in;
	assign unused_in = push ^ (|rx_byte);

	`DETX_ASSERT_ALWAYS(a_reset_idle, (!arst_n) |-> (empty && !full), "queues not empty in reset")

	`DETX_ASSERT_RUN(a_result_hold, (!empty && !pop) |=> (!empty && $stable(kind) && $stable(payload_value) && $stable(payload_index) && $stable(frame_command) && $stable(frame_size) && $stable(checksum_ok)), "stalled result changed")

	`DETX_ASSERT_RUN(a_end_fields, (!empty && kind) |-> (payload_value == 8'h00 && payload_index == 8'h00), "frame end carries payload fields")

	`DETX_ASSERT_RUN(a_payload_fields, (!empty && !kind) |-> (frame_command == 8'h00 && frame_size == 8'h00 && !checksum_ok), "payload result carries frame fields")

endmodule

bind dle_etx_deframer_checksum_top detx_checker u_detx_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.push          (push),
	.full          (full),
	.rx_byte       (rx_byte),
	.empty         (empty),
	.pop           (pop),
	.kind          (kind),
	.payload_value (payload_value),
	.payload_index (payload_index),
	.frame_command (frame_command),
	.frame_size    (frame_size),
	.checksum_ok   (checksum_ok)
);
